// ===== rtl/tlbfl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the FIFO/LRU TLB.
// No dependencies; used by every other file of the block.
package tlbfl_pkg;

  localparam int TLB_DEPTH = 16;
  localparam int IDX_W     = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int CNT_W     = $clog2(TLB_DEPTH + 1);

  localparam int KIND_W    = 2;
  localparam int PID_W     = 16;
  localparam int PAGE_W    = 20;
  localparam int FRAME_W   = 20;
  localparam int STAMP_W   = 32;

  localparam int ENTRIES_W = 5;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [ENTRIES_W-1:0] ENTRIES_RST = 5'd16;
  localparam logic                 POLICY_FIFO = 1'b0;
  localparam logic                 POLICY_LRU  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TOUCH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILL   = 2'd2;

  localparam logic REG_ENTRIES = 1'b0;
  localparam logic REG_POLICY  = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic scan_start;
    logic scan_step;
    logic evict;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/tlbfl_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one TLB request word with valid/ready handshake.
// Depends on tlbfl_pkg for field widths.
interface tlbfl_in_if;
  logic                          valid;
  logic                          ready;
  logic [tlbfl_pkg::KIND_W-1:0]  kind;
  logic [tlbfl_pkg::PID_W-1:0]   pid;
  logic [tlbfl_pkg::PAGE_W-1:0]  page;
  logic [tlbfl_pkg::FRAME_W-1:0] frame_in;

  modport source (output valid, kind, pid, page, frame_in, input ready);
  modport sink   (input valid, kind, pid, page, frame_in, output ready);
endinterface

// ===== rtl/tlbfl_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: one TLB response word with valid/ready handshake.
// Depends on tlbfl_pkg for field widths.
interface tlbfl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [tlbfl_pkg::FRAME_W-1:0] frame_out;
  logic                          evicted;

  modport source (output valid, hit, frame_out, evicted, input ready);
  modport sink   (input valid, hit, frame_out, evicted, output ready);
endinterface

// ===== rtl/tlb_fifo_lru_replacement_unit.sv =====
`timescale 1ns / 1ps
// Fully associative TLB keyed by (pid, page) with FIFO or LRU replacement.
// Depends on tlbfl_pkg, tlbfl_in_if, tlbfl_out_if, tlbfl_regs, tlbfl_ctrl, tlbfl_dpath.
//
// Usage:
//   in_ch  : request words (kind, pid, page, frame_in), valid/ready.
//   out_ch : one response word per request (hit, frame_out, evicted).
//   APB    : reg 0 entries_in_use (addr 0, writing it invalidates all entries),
//            reg 1 replace_policy (addr 4, 0 FIFO, 1 LRU). pready is tied high.
// Timing:
//   A request is taken in one cycle and matched against all active entries
//   in the next; the response is registered at the end of that cycle when the
//   response register is free, and no new request is taken before then.
//   A fill that misses with every active entry valid scans the active entries
//   for the oldest stamp, one entry per cycle, then evicts that entry.
// Reset: all entries invalid, 16 entries in use, FIFO policy, stamp clocks 0.
// Stall: the response register holds until taken; one further request can
//   be accepted meanwhile and waits in the match cycle for the register.
module tlb_fifo_lru_replacement_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  tlbfl_in_if.sink                       in_ch,
  tlbfl_out_if.source                    out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlbfl_pkg::PADDR_W-1:0]  paddr,
  input  logic [tlbfl_pkg::PDATA_W-1:0]  pwdata,
  output logic [tlbfl_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready
);

  logic [tlbfl_pkg::ENTRIES_W-1:0] entries;
  logic                            policy;
  logic                            clear_slots;
  tlbfl_pkg::ctrl_cmd_t            cmd;
  tlbfl_pkg::ctrl_sts_t            sts;

  tlbfl_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .entries     (entries),
    .policy      (policy),
    .clear_slots (clear_slots)
  );

  tlbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlbfl_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .entries     (entries),
    .policy      (policy),
    .clear_slots (clear_slots),
    .in_kind     (in_ch.kind),
    .in_pid      (in_ch.pid),
    .in_page     (in_ch.page),
    .in_frame    (in_ch.frame_in),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_hit     (out_ch.hit),
    .out_frame   (out_ch.frame_out),
    .out_evicted (out_ch.evicted)
  );

endmodule

// ===== rtl/tlbfl_regs.sv =====
`timescale 1ns / 1ps
// APB-style configuration registers: entries_in_use and replace_policy.
// Depends on tlbfl_pkg; emits a clear pulse on every entries_in_use write.
module tlbfl_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlbfl_pkg::PADDR_W-1:0]  paddr,
  input  logic [tlbfl_pkg::PDATA_W-1:0]  pwdata,
  output logic [tlbfl_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready,
  output logic [tlbfl_pkg::ENTRIES_W-1:0] entries,
  output logic                           policy,
  output logic                           clear_slots
);

  logic                            wr;
  logic                            reg_sel;
  logic [tlbfl_pkg::ENTRIES_W-1:0] entries_r;
  logic                            policy_r;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  assign clear_slots = wr && (reg_sel == tlbfl_pkg::REG_ENTRIES);
  assign entries     = entries_r;
  assign policy      = policy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= tlbfl_pkg::ENTRIES_RST;
      policy_r  <= tlbfl_pkg::POLICY_FIFO;
    end else if (wr) begin
      unique case (reg_sel)
        tlbfl_pkg::REG_ENTRIES: entries_r <= pwdata[tlbfl_pkg::ENTRIES_W-1:0];
        tlbfl_pkg::REG_POLICY:  policy_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      tlbfl_pkg::REG_ENTRIES: prdata[tlbfl_pkg::ENTRIES_W-1:0] = entries_r;
      tlbfl_pkg::REG_POLICY:  prdata[0] = policy_r;
      default: ;
    endcase
  end

endmodule

// ===== rtl/tlbfl_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences accept, lookup/commit, victim scan and eviction.
// Depends on tlbfl_pkg for the command and status structs.
module tlbfl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tlbfl_pkg::ctrl_sts_t  sts,
  output tlbfl_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_EVICT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.need_scan) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        if (sts.out_free) begin
          cmd.evict = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/tlbfl_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: slot storage, parallel key match, stamp clocks, victim scan
// and the result register. Depends on tlbfl_pkg; driven by tlbfl_ctrl.
module tlbfl_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tlbfl_pkg::ctrl_cmd_t            cmd,
  output tlbfl_pkg::ctrl_sts_t            sts,
  input  logic [tlbfl_pkg::ENTRIES_W-1:0] entries,
  input  logic                            policy,
  input  logic                            clear_slots,
  input  logic [tlbfl_pkg::KIND_W-1:0]    in_kind,
  input  logic [tlbfl_pkg::PID_W-1:0]     in_pid,
  input  logic [tlbfl_pkg::PAGE_W-1:0]    in_page,
  input  logic [tlbfl_pkg::FRAME_W-1:0]   in_frame,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic [tlbfl_pkg::FRAME_W-1:0]   out_frame,
  output logic                            out_evicted
);

  localparam int D = tlbfl_pkg::TLB_DEPTH;

  logic [tlbfl_pkg::KIND_W-1:0]  kind_r;
  logic [tlbfl_pkg::PID_W-1:0]   pid_r;
  logic [tlbfl_pkg::PAGE_W-1:0]  page_r;
  logic [tlbfl_pkg::FRAME_W-1:0] frame_r;

  logic [D-1:0]                  valid_r;
  logic [tlbfl_pkg::PID_W-1:0]   slot_pid_r   [D];
  logic [tlbfl_pkg::PAGE_W-1:0]  slot_page_r  [D];
  logic [tlbfl_pkg::FRAME_W-1:0] slot_frame_r [D];
  logic [tlbfl_pkg::STAMP_W-1:0] slot_fill_r  [D];
  logic [tlbfl_pkg::STAMP_W-1:0] slot_use_r   [D];
  logic [tlbfl_pkg::STAMP_W-1:0] use_clk_r;
  logic [tlbfl_pkg::STAMP_W-1:0] fill_clk_r;

  tlbfl_pkg::idx_t               scan_idx_r;
  tlbfl_pkg::idx_t               best_idx_r;
  logic [tlbfl_pkg::STAMP_W-1:0] best_age_r;

  logic                          out_valid_r;
  logic                          out_hit_r;
  logic [tlbfl_pkg::FRAME_W-1:0] out_frame_r;
  logic                          out_evicted_r;

  tlbfl_pkg::cnt_t               n_act;
  logic [D-1:0]                  active;
  logic [D-1:0]                  hit_vec;
  logic [D-1:0]                  free_vec;
  logic                          hit;
  logic                          any_free;
  tlbfl_pkg::idx_t               hit_idx;
  tlbfl_pkg::idx_t               free_idx;
  logic                          is_fill;
  logic                          is_touch;
  logic [tlbfl_pkg::STAMP_W-1:0] scan_stamp;
  logic [tlbfl_pkg::STAMP_W-1:0] scan_age;
  logic                          upd_stamp;
  logic                          upd_frame;
  logic                          insert;
  tlbfl_pkg::idx_t               ins_idx;
  logic                          out_free;

  assign n_act = (int'(entries) > D) ? tlbfl_pkg::CNT_W'(D)
                                     : tlbfl_pkg::CNT_W'(entries);

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < D; i++) begin
      active[i]   = tlbfl_pkg::CNT_W'(i) < n_act;
      hit_vec[i]  = valid_r[i] && active[i] && (slot_pid_r[i] == pid_r)
                    && (slot_page_r[i] == page_r);
      free_vec[i] = !valid_r[i] && active[i];
    end
    for (int i = D - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = tlbfl_pkg::IDX_W'(i);
      end
      if (free_vec[i]) begin
        free_idx = tlbfl_pkg::IDX_W'(i);
      end
    end
  end

  assign hit      = |hit_vec;
  assign any_free = |free_vec;
  assign is_fill  = (kind_r == tlbfl_pkg::KIND_FILL);
  assign is_touch = (kind_r == tlbfl_pkg::KIND_TOUCH);

  assign scan_stamp = (policy == tlbfl_pkg::POLICY_LRU) ? slot_use_r[scan_idx_r]
                                                        : slot_fill_r[scan_idx_r];
  assign scan_age   = (policy == tlbfl_pkg::POLICY_LRU) ? use_clk_r - scan_stamp
                                                        : fill_clk_r - scan_stamp;

  assign upd_stamp = cmd.commit && hit && (is_touch || is_fill);
  assign upd_frame = cmd.commit && hit && is_fill;
  assign insert    = (cmd.commit && !hit && is_fill && (n_act != '0) && any_free)
                     || cmd.evict;
  assign ins_idx   = cmd.evict ? best_idx_r : free_idx;

  assign out_free = !out_valid_r || out_ready;

  assign sts.need_scan = is_fill && !hit && (n_act != '0) && !any_free;
  assign sts.scan_last = (tlbfl_pkg::CNT_W'(scan_idx_r) == n_act - tlbfl_pkg::CNT_W'(1));
  assign sts.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      pid_r   <= in_pid;
      page_r  <= in_page;
      frame_r <= in_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      use_clk_r  <= '0;
      fill_clk_r <= '0;
    end else begin
      if (clear_slots) begin
        valid_r <= '0;
      end else if (insert) begin
        valid_r[ins_idx] <= 1'b1;
      end
      if (upd_stamp || insert) begin
        use_clk_r <= use_clk_r + 1'b1;
      end
      if (insert) begin
        fill_clk_r <= fill_clk_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_stamp) begin
      slot_use_r[hit_idx] <= use_clk_r;
    end
    if (upd_frame) begin
      slot_frame_r[hit_idx] <= frame_r;
    end
    if (insert) begin
      slot_pid_r[ins_idx]   <= pid_r;
      slot_page_r[ins_idx]  <= page_r;
      slot_frame_r[ins_idx] <= frame_r;
      slot_use_r[ins_idx]   <= use_clk_r;
      slot_fill_r[ins_idx]  <= fill_clk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if ((scan_idx_r == '0) || (scan_age > best_age_r)) begin
        best_idx_r <= scan_idx_r;
        best_age_r <= scan_age;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit || cmd.evict) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit || cmd.evict) begin
      out_hit_r     <= cmd.commit && hit;
      out_frame_r   <= (cmd.commit && hit) ? slot_frame_r[hit_idx] : '0;
      out_evicted_r <= cmd.evict;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_frame   = out_frame_r;
  assign out_evicted = out_evicted_r;

endmodule
